FILE: rtl/mclfs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the light fade sequencer.
// Used by every other file of the block but mclfs_ram; depends on nothing.
package mclfs_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Register file layout: pause lengths first, then fade lengths.
	localparam int NUM_REG_CH = 4;
	localparam int REG_PAUSE_BASE = 0;
	localparam int REG_FADE_BASE = 4;
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam int PAUSE_W = 16;
	localparam int FADE_W = 12;
	localparam int STEP_W = 14;
	localparam int LEVEL_W = 8;
	localparam int OUT_CH_W = 2;

	localparam logic [PAUSE_W-1:0] PAUSE_RST = PAUSE_W'(5);
	localparam logic [FADE_W-1:0] FADE_RST = FADE_W'(5);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// step = fade * 1000 / 255, as fade * (1000 * ceil(2^30 / 255)) >> 30.
	// Exact for every 12-bit fade length.
	localparam int RECIP_SHIFT = 30;
	localparam logic [31:0] STEP_MULT = 32'd4210753000;
	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(19);

	typedef struct packed {
		logic               phase_on;
		logic [LEVEL_W-1:0] bright;
		logic [31:0]        phase_start_sec;
		logic [31:0]        step_time_ms;
	} ch_state_t;

	typedef struct packed {
		logic [PAUSE_W-1:0] pause_time;
		logic [FADE_W-1:0]  fade_time;
		logic [STEP_W-1:0]  step_len;
	} ch_cfg_t;

endpackage

FILE: rtl/mclfs_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: tick input, per-channel result, register write.
// Widths come from mclfs_pkg.
interface mclfs_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_seconds;
	logic [31:0] now_millis;

	modport source (output valid, output now_seconds, output now_millis, input ready);
	modport sink (input valid, input now_seconds, input now_millis, output ready);
endinterface

interface mclfs_res_if;
	logic                              valid;
	logic                              ready;
	logic [mclfs_pkg::OUT_CH_W-1:0]    channel;
	logic [mclfs_pkg::LEVEL_W-1:0]     level;
	logic                              fading_in;
	logic                              last;

	modport source (output valid, output channel, output level, output fading_in,
		output last, input ready);
	modport sink (input valid, input channel, input level, input fading_in,
		input last, output ready);
endinterface

interface mclfs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mclfs_pkg::CFG_IDX_W-1:0]    index;
	logic [mclfs_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mclfs_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mclfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int ADDR_W = 2
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low, so a stalled consumer keeps its operand.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/mclfs_cfg.sv
`timescale 1ns / 1ps
// Configuration registers: per-channel pause and fade lengths plus the
// precomputed fade step length. Depends on mclfs_pkg and mclfs_cfg_if.
module mclfs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	mclfs_cfg_if.sink                   cfg,
	input  logic [mclfs_pkg::CH_W-1:0]  ch,
	output mclfs_pkg::ch_cfg_t          ch_cfg
);

	logic [mclfs_pkg::PAUSE_W-1:0] pause_q [mclfs_pkg::NUM_REG_CH];
	logic [mclfs_pkg::FADE_W-1:0]  fade_q [mclfs_pkg::NUM_REG_CH];
	logic [mclfs_pkg::STEP_W-1:0]  step_q [mclfs_pkg::NUM_REG_CH];
	logic [mclfs_pkg::FADE_W-1:0]  wr_fade;
	logic [43:0]                   step_prod;
	logic [1:0]                    wr_slot;
	logic [1:0]                    rd_slot;
	logic                          wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;
	assign wr_fade = cfg.data[mclfs_pkg::FADE_W-1:0];
	assign step_prod = {32'b0, wr_fade} * {12'b0, mclfs_pkg::STEP_MULT};
	assign wr_slot = cfg.index[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mclfs_pkg::NUM_REG_CH; k++) begin
				pause_q[k] <= mclfs_pkg::PAUSE_RST;
				fade_q[k] <= mclfs_pkg::FADE_RST;
				step_q[k] <= mclfs_pkg::STEP_RST;
			end
		end else if (wr) begin
			priority if (cfg.index < mclfs_pkg::CFG_IDX_W'(mclfs_pkg::REG_FADE_BASE)) begin
				pause_q[wr_slot] <= cfg.data[mclfs_pkg::PAUSE_W-1:0];
			end else if (cfg.index < mclfs_pkg::CFG_IDX_W'(mclfs_pkg::NUM_REGS)) begin
				fade_q[wr_slot] <= wr_fade;
				step_q[wr_slot] <=
					step_prod[mclfs_pkg::RECIP_SHIFT +: mclfs_pkg::STEP_W];
			end else begin
				// Writes beyond the register list are dropped.
			end
		end
	end

	assign rd_slot = 2'(ch);
	assign ch_cfg.pause_time = pause_q[rd_slot];
	assign ch_cfg.fade_time = fade_q[rd_slot];
	assign ch_cfg.step_len = step_q[rd_slot];

endmodule

FILE: rtl/mclfs_upd.sv
`timescale 1ns / 1ps
// Per-channel update: phase timing and level step for one channel entry.
// Depends on mclfs_pkg.
module mclfs_upd (
	input  mclfs_pkg::ch_state_t cur,
	input  mclfs_pkg::ch_cfg_t   ch_cfg,
	input  logic [31:0]          sec,
	input  logic [31:0]          ms,
	output mclfs_pkg::ch_state_t nxt
);

	logic [31:0] since_step;
	logic [31:0] since_phase;

	assign since_step = ms - cur.step_time_ms;
	assign since_phase = sec - cur.phase_start_sec;

	always_comb begin
		nxt = cur;
		if (!cur.phase_on) begin
			// Pause: fall by one whenever the millisecond time has moved on.
			if (since_step != 32'd0 && cur.bright != '0) begin
				nxt.bright = cur.bright - 1'b1;
			end
			if (since_phase >= {16'b0, ch_cfg.pause_time}) begin
				nxt.phase_on = 1'b1;
				nxt.phase_start_sec = sec;
			end
		end else begin
			if (since_step >= {18'b0, ch_cfg.step_len} &&
				cur.bright != mclfs_pkg::LEVEL_MAX) begin
				nxt.bright = cur.bright + 1'b1;
				nxt.step_time_ms = ms;
			end
			if (since_phase >= {20'b0, ch_cfg.fade_time}) begin
				nxt.phase_on = 1'b0;
				nxt.phase_start_sec = sec;
			end
		end
	end

endmodule

FILE: rtl/multi_channel_light_fade_sequencer_core.sv
`timescale 1ns / 1ps
// Light fade sequencer top level. Channel state lives in a RAM; its registered
// read data feeds the update stage. After a tick is accepted, each channel is
// read and updated in turn; the next tick is taken only once the last channel
// has left the update stage. Each result is registered at the output.
// Output stalls hold the update stage. Reset clears control and restores the
// default register values; channel state reads as zero until first written.
module multi_channel_light_fade_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	mclfs_tick_if.sink  tick,
	mclfs_res_if.source res,
	mclfs_cfg_if.sink   cfg
);

	typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

	localparam int ST_W = $bits(mclfs_pkg::ch_state_t);
	localparam logic [mclfs_pkg::CH_W-1:0] LAST_CH = mclfs_pkg::CH_W'(mclfs_pkg::CHANNELS - 1);

	seq_state_t                    state_q;
	logic [mclfs_pkg::CH_W-1:0]    rd_ch_q;
	logic [31:0]                   sec_q;
	logic [31:0]                   ms_q;
	logic                          valid_s1;
	logic [mclfs_pkg::CH_W-1:0]    ch_s1;
	logic                          rvld_s1;
	logic [mclfs_pkg::CHANNELS-1:0] ent_vld_q;
	logic                          out_valid_q;
	logic [mclfs_pkg::OUT_CH_W-1:0] out_ch_q;
	logic [mclfs_pkg::LEVEL_W-1:0] out_level_q;
	logic                          out_fade_q;
	logic                          out_last_q;

	logic                          tick_acc;
	logic                          iss;
	logic                          adv;
	logic [ST_W-1:0]               ram_rdata;
	mclfs_pkg::ch_state_t          cur;
	mclfs_pkg::ch_state_t          nxt;
	mclfs_pkg::ch_cfg_t            ch_cfg;

	assign tick.ready = (state_q == ST_IDLE) && !valid_s1;
	assign tick_acc = tick.valid & tick.ready;
	assign adv = valid_s1 && (!out_valid_q || res.ready);
	assign iss = (state_q == ST_RUN) && (!valid_s1 || adv);

	mclfs_ram #(
		.WIDTH (ST_W),
		.DEPTH (mclfs_pkg::CHANNELS),
		.ADDR_W(mclfs_pkg::CH_W)
	) u_ram (
		.clk  (clk),
		.we   (adv),
		.waddr(ch_s1),
		.wdata(nxt),
		.re   (iss),
		.raddr(rd_ch_q),
		.rdata(ram_rdata)
	);

	mclfs_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.ch    (ch_s1),
		.ch_cfg(ch_cfg)
	);

	// Entries never written since reset read as the all-zero reset state.
	assign cur = rvld_s1 ? mclfs_pkg::ch_state_t'(ram_rdata) : '0;

	mclfs_upd u_upd (
		.cur   (cur),
		.ch_cfg(ch_cfg),
		.sec   (sec_q),
		.ms    (ms_q),
		.nxt   (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_ch_q <= '0;
			valid_s1 <= 1'b0;
			ent_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				state_q <= ST_RUN;
				rd_ch_q <= '0;
			end else if (iss) begin
				if (rd_ch_q == LAST_CH) begin
					state_q <= ST_IDLE;
					rd_ch_q <= '0;
				end else begin
					rd_ch_q <= rd_ch_q + 1'b1;
				end
			end

			if (iss) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				ent_vld_q[ch_s1] <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			sec_q <= tick.now_seconds;
			ms_q <= tick.now_millis;
		end
		if (iss) begin
			ch_s1 <= rd_ch_q;
			rvld_s1 <= ent_vld_q[rd_ch_q];
		end
		if (adv) begin
			out_ch_q <= mclfs_pkg::OUT_CH_W'(ch_s1);
			out_level_q <= nxt.bright;
			out_fade_q <= nxt.phase_on;
			out_last_q <= (ch_s1 == LAST_CH);
		end
	end

	assign res.valid = out_valid_q;
	assign res.channel = out_ch_q;
	assign res.level = out_level_q;
	assign res.fading_in = out_fade_q;
	assign res.last = out_last_q;

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(ch_s1))
		else $error("update stage lost its entry during an output stall");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> state_q == ST_RUN && rd_ch_q == '0)
		else $error("tick transaction did not restart the channel sweep");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ch_s1 == LAST_CH |=> res.valid && res.last)
		else $error("final channel result not marked last");
`endif

endmodule
